FILE: design/gated_broadcast_ring_buffer_assert.svh
// Assertion macros shared by the ring buffer RTL
`ifndef GATED_BROADCAST_RING_BUFFER_ASSERT_SVH
`define GATED_BROADCAST_RING_BUFFER_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication, checked on every rising edge outside reset
`define GBRB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define GBRB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GBRB_ASSERT_IMP(lbl, ante, cons, msg)
`define GBRB_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

FILE: design/gbrb_pkg.sv
// Shared types and constants for the gated broadcast ring buffer
package gbrb_pkg;

    // sizing
    localparam int RING_DEPTH  = 1024;
    localparam int MAX_READERS = 8;
    localparam int SEQ_W       = 48;
    localparam int DATA_W      = 64;
    localparam int READER_W    = 3;
    localparam int ACT_W       = 4;
    localparam int ADDR_W      = $clog2(RING_DEPTH);
    localparam int IDX_W       = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
    localparam int CNT_W       = $clog2(MAX_READERS + 1);

    // sequence constants
    localparam logic signed [SEQ_W-1:0] SEQ_MAX       = {1'b0, {(SEQ_W-1){1'b1}}};
    localparam logic signed [SEQ_W-1:0] SEQ_MINUS_ONE = '1;
    localparam logic signed [SEQ_W-1:0] SEQ_ONE       = SEQ_W'(1);
    localparam logic signed [SEQ_W-1:0] SEQ_DEPTH     = SEQ_W'(RING_DEPTH);
    localparam logic [ACT_W-1:0]        ACTIVE_RESET  = ACT_W'(4);

    typedef enum logic [1:0] {
        OP_PUBLISH = 2'd0,
        OP_READ    = 2'd1,
        OP_RELEASE = 2'd2,
        OP_NOP     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_NOT_AVAIL  = 2'd2,
        ST_BAD_READER = 2'd3
    } status_t;

    typedef struct packed {
        op_t                       op;
        logic [READER_W-1:0]       reader;
        logic signed [SEQ_W-1:0]   seq_in;
        logic [DATA_W-1:0]         payload_in;
    } req_t;

    typedef struct packed {
        status_t                   status;
        logic signed [SEQ_W-1:0]   seq_out;
        logic [DATA_W-1:0]         payload_out;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic scan_step;
        logic scan_end;
        logic read_done;
        logic load_out;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        op_t  op;
        logic need_scan;
        logic scan_done;
    } dp_sts_t;

endpackage

FILE: design/gbrb_ram.sv
// Generic single-write, single-read RAM with registered read data
module gbrb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/gbrb_dp.sv
// Datapath: sequence registers, reader positions, gate scan, ring memory, result
`include "gated_broadcast_ring_buffer_assert.svh"
module gbrb_dp import gbrb_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  dp_cmd_t          cmd,
    output dp_sts_t          sts,
    input  req_t             req,
    output rsp_t             rsp,
    input  logic             cfg_we,
    input  logic [ACT_W-1:0] cfg_wdata
);

    // architectural state
    logic signed [SEQ_W-1:0] cursor_reg, cursor_next;
    logic signed [SEQ_W-1:0] claim_reg, claim_next;
    logic signed [SEQ_W-1:0] gate_reg, gate_next;
    logic signed [SEQ_W-1:0] pos_reg [MAX_READERS];
    logic [ACT_W-1:0]        active_reg;

    // per-item working registers
    req_t                    item_reg;
    rsp_t                    result_reg, result_next;
    rsp_t                    rsp_reg;
    logic                    rd_ok_reg, rd_ok_next;
    logic signed [SEQ_W-1:0] scan_min_reg, scan_min_next;
    logic [CNT_W-1:0]        scan_idx_reg, scan_idx_next;

    // combinational helpers
    logic signed [SEQ_W-1:0] floor_seq;
    logic signed [SEQ_W-1:0] scan_pos;
    logic [CNT_W-1:0]        n_readers;
    logic [IDX_W-1:0]        rel_idx;
    logic                    rel_bad;
    logic                    pos_we;
    logic                    ram_we;
    logic                    ram_re;
    logic [DATA_W-1:0]       ram_rdata;

    // number of readers that take part in gating
    assign n_readers = (int'(active_reg) > MAX_READERS) ? CNT_W'(MAX_READERS)
                                                        : CNT_W'(active_reg);
    assign floor_seq = claim_reg - SEQ_DEPTH;
    assign scan_pos  = pos_reg[scan_idx_reg[IDX_W-1:0]];
    assign rel_idx   = IDX_W'(item_reg.reader);
    assign rel_bad   = int'(item_reg.reader) >= MAX_READERS;

    // status to the controller
    assign sts.op        = item_reg.op;
    assign sts.need_scan = (claim_reg != SEQ_MAX) && (claim_reg >= SEQ_DEPTH)
                           && (gate_reg < floor_seq);
    assign sts.scan_done = scan_idx_reg >= n_readers;

    // next-state logic for one item
    always_comb
    begin
        cursor_next   = cursor_reg;
        claim_next    = claim_reg;
        gate_next     = gate_reg;
        result_next   = result_reg;
        rd_ok_next    = rd_ok_reg;
        scan_min_next = scan_min_reg;
        scan_idx_next = scan_idx_reg;
        pos_we        = 1'b0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;

        if (cmd.exec)
        begin
            result_next = '{status: ST_OK, seq_out: '0, payload_out: '0};
            unique case (item_reg.op)
                OP_PUBLISH:
                begin
                    result_next.seq_out = claim_reg;
                    priority if (claim_reg == SEQ_MAX)
                    begin
                        // sequence space used up
                        result_next.status = ST_FULL;
                    end
                    else if (sts.need_scan)
                    begin
                        scan_min_next = SEQ_MAX;
                        scan_idx_next = '0;
                    end
                    else
                    begin
                        ram_we      = 1'b1;
                        cursor_next = claim_reg;
                        claim_next  = claim_reg + SEQ_ONE;
                    end
                end
                OP_READ:
                begin
                    result_next.seq_out = cursor_reg;
                    if (cursor_reg < item_reg.seq_in)
                    begin
                        result_next.status = ST_NOT_AVAIL;
                        rd_ok_next         = 1'b0;
                    end
                    else
                    begin
                        rd_ok_next = 1'b1;
                        ram_re     = 1'b1;
                    end
                end
                OP_RELEASE:
                begin
                    if (rel_bad)
                    begin
                        result_next.status = ST_BAD_READER;
                    end
                    else
                    begin
                        pos_we = 1'b1;
                    end
                end
                OP_NOP:
                begin
                    result_next.status = ST_OK;
                end
            endcase
        end

        // one reader position per cycle into the running minimum
        if (cmd.scan_step)
        begin
            if (scan_pos < scan_min_reg)
            begin
                scan_min_next = scan_pos;
            end
            scan_idx_next = scan_idx_reg + CNT_W'(1);
        end

        // refreshed gate decides the publish
        if (cmd.scan_end)
        begin
            gate_next = scan_min_reg;
            if (scan_min_reg < floor_seq)
            begin
                result_next.status = ST_FULL;
            end
            else
            begin
                ram_we      = 1'b1;
                cursor_next = claim_reg;
                claim_next  = claim_reg + SEQ_ONE;
            end
        end

        if (cmd.read_done)
        begin
            result_next.payload_out = rd_ok_reg ? ram_rdata : '0;
        end
    end

    // state with reset values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg   <= SEQ_MINUS_ONE;
            claim_reg    <= '0;
            gate_reg     <= SEQ_MINUS_ONE;
            active_reg   <= ACTIVE_RESET;
            scan_idx_reg <= '0;
            for (int i = 0; i < MAX_READERS; i++)
            begin
                pos_reg[i] <= SEQ_MINUS_ONE;
            end
        end
        else
        begin
            cursor_reg   <= cursor_next;
            claim_reg    <= claim_next;
            gate_reg     <= gate_next;
            scan_idx_reg <= scan_idx_next;
            if (cfg_we)
            begin
                active_reg <= cfg_wdata;
            end
            if (pos_we)
            begin
                pos_reg[rel_idx] <= item_reg.seq_in;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= req;
        end
        result_reg   <= result_next;
        rd_ok_reg    <= rd_ok_next;
        scan_min_reg <= scan_min_next;
        if (cmd.load_out)
        begin
            rsp_reg <= result_reg;
        end
    end

    assign rsp = rsp_reg;

    // ring storage
    gbrb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (claim_reg[ADDR_W-1:0]),
        .wdata (item_reg.payload_in),
        .re    (ram_re),
        .raddr (item_reg.seq_in[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // cursor always trails the next claim by exactly one
    `GBRB_ASSERT_IMP(a_cursor_trails_claim, 1'b1, cursor_reg + SEQ_ONE == claim_reg, "cursor and claim out of step")
    // the scan never steps past the active readers
    `GBRB_ASSERT_IMP(a_scan_in_range, cmd.scan_step, scan_idx_reg < n_readers, "gate scan past active readers")
    // a publish never commits once the sequence space is exhausted
    `GBRB_ASSERT_IMP(a_no_commit_at_max, ram_we, claim_reg != SEQ_MAX, "publish committed at max sequence")

endmodule

FILE: design/gbrb_ctrl.sv
// Controller: item sequencing and output register handshake
`include "gated_broadcast_ring_buffer_assert.svh"
module gbrb_ctrl import gbrb_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_stall,
    output logic    rsp_valid,
    input  logic    rsp_stall,
    output dp_cmd_t cmd,
    input  dp_sts_t sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_READ,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   out_free;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = state_reg != S_IDLE;
    assign rsp_valid = rsp_valid_reg;

    // sequencing and commands
    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        cmd            = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                unique case (sts.op)
                    OP_PUBLISH: state_next = sts.need_scan ? S_SCAN : S_FINISH;
                    OP_READ:    state_next = S_READ;
                    OP_RELEASE: state_next = S_FINISH;
                    OP_NOP:     state_next = S_FINISH;
                endcase
            end
            S_SCAN:
            begin
                if (sts.scan_done)
                begin
                    cmd.scan_end = 1'b1;
                    state_next   = S_FINISH;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_READ:
            begin
                cmd.read_done = 1'b1;
                state_next    = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // a result never overwrites one that is still waiting
    `GBRB_ASSERT_IMP(a_load_when_free, cmd.load_out, !rsp_valid_reg || !rsp_stall, "output overwritten")
    // a finished scan always hands over to the result stage
    `GBRB_ASSERT_NXT(a_scan_exit, state_reg == S_SCAN && sts.scan_done, state_reg == S_FINISH, "scan did not finish")
    // an accepted item is executed in the next cycle
    `GBRB_ASSERT_NXT(a_accept_exec, req_valid && !req_stall, state_reg == S_EXEC, "accepted item not executed")

endmodule

FILE: design/gated_broadcast_ring_buffer.sv
// Top level of the gated broadcast ring buffer
//
// Single-producer ring with up to MAX_READERS readers that each see every
// entry. Requests arrive on req (valid/stall); each transfer yields exactly
// one response on rsp (valid/stall). Op publish writes payload_in at the
// next sequence unless the slowest active reader is more than one lap
// behind (status full); op read returns the entry at seq_in and the cursor;
// op release stores a reader's consumed position.
// The block works on one request at a time. Each request is captured, then
// executed; a read then waits on the registered ring memory read, and a
// publish that must refresh the gate first scans the active readers,
// visiting one reader position per cycle. The response is then loaded into
// the output register, and only after that is a new request taken.
// The response sits in an output register: a stall on rsp holds it while
// the next request is already taken and worked on up to its result.
// Reset clears cursor to -1, next claim to 0, cached gate and every reader
// position to -1, and active_readers to 4; ring contents are undefined.
// cfg_we writes active_readers; the user uses it only while the block is idle, unenforced.
module gated_broadcast_ring_buffer import gbrb_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  req_t             req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output rsp_t             rsp,
    input  logic             cfg_we,
    input  logic [ACT_W-1:0] cfg_wdata
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    gbrb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    gbrb_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

endmodule

FILE: tb/gated_broadcast_ring_buffer_check.sv
// Checker for the gated broadcast ring buffer: shadow ring state and response compare
module gated_broadcast_ring_buffer_check
    import gbrb_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    input  logic                    req_stall,
    input  req_t                    req,
    input  logic                    rsp_valid,
    input  logic                    rsp_stall,
    input  rsp_t                    rsp,
    input  logic                    cfg_we,
    input  logic [ACT_W-1:0]        cfg_wdata,
    output int                      fail_count,
    output int                      pending,
    output logic signed [SEQ_W-1:0] cursor_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow of the block's state
    logic [DATA_W-1:0]       ring_shadow [RING_DEPTH];
    logic signed [SEQ_W-1:0] cursor;
    logic signed [SEQ_W-1:0] next_seq;
    logic signed [SEQ_W-1:0] gate_cache;
    logic signed [SEQ_W-1:0] reader_pos [MAX_READERS];
    logic [ACT_W-1:0]        active_cnt;

    // responses owed by the block, oldest first
    rsp_t rsp_due [$];

    assign cursor_seen = cursor;

    // minimum release position over the readers taking part in gating
    function automatic logic signed [SEQ_W-1:0] slowest_reader();
        int                      lanes;
        logic signed [SEQ_W-1:0] low;
        lanes = (active_cnt > MAX_READERS) ? MAX_READERS : int'(active_cnt);
        low = SEQ_MAX;
        for (int i = 0; i < lanes; i++)
            if (reader_pos[i] < low)
                low = reader_pos[i];
        return low;
    endfunction

    // apply one request to the shadow state and return the response it owes
    function automatic rsp_t predict_rsp(input req_t r);
        rsp_t                    res;
        logic signed [SEQ_W-1:0] attempt;
        logic signed [SEQ_W-1:0] lap_floor;
        logic signed [SEQ_W-1:0] target_seq;
        bit                      granted;
        res = '0;
        target_seq = $signed(r.seq_in);
        case (r.op)
            OP_PUBLISH:
            begin
                attempt = next_seq;
                granted = (attempt != SEQ_MAX);
                // gate is rescanned only when the cached value says we may lap a reader
                if (granted && attempt >= SEQ_DEPTH)
                begin
                    lap_floor = attempt - SEQ_DEPTH;
                    if (gate_cache < lap_floor)
                    begin
                        gate_cache = slowest_reader();
                        if (gate_cache < lap_floor)
                            granted = 1'b0;
                    end
                end
                res.seq_out = attempt;
                if (granted)
                begin
                    ring_shadow[attempt[ADDR_W-1:0]] = r.payload_in;
                    cursor = attempt;
                    next_seq = attempt + SEQ_ONE;
                end
                else
                    res.status = ST_FULL;
            end
            OP_READ:
            begin
                res.seq_out = cursor;
                if (cursor < target_seq)
                    res.status = ST_NOT_AVAIL;
                else
                    res.payload_out = ring_shadow[target_seq[ADDR_W-1:0]];
            end
            OP_RELEASE:
            begin
                if (r.reader >= MAX_READERS)
                    res.status = ST_BAD_READER;
                else
                    reader_pos[r.reader] = target_seq;
            end
            default:
                ;
        endcase
        return res;
    endfunction

    // field by field compare against the oldest owed response
    task automatic compare_rsp(input rsp_t got);
        rsp_t want;
        if (rsp_due.size() == 0)
        begin
            $display("%0t: response with none owed: status %0d seq %0d payload %h",
                     $time, got.status, got.seq_out, got.payload_out);
            fail_count++;
            return;
        end
        want = rsp_due.pop_front();
        if (got.status !== want.status)
        begin
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, want.status, got.status);
            fail_count++;
        end
        if (got.seq_out !== want.seq_out)
        begin
            $display("%0t: seq_out mismatch: expected %0d actual %0d",
                     $time, want.seq_out, got.seq_out);
            fail_count++;
        end
        if (got.payload_out !== want.payload_out)
        begin
            $display("%0t: payload_out mismatch: expected %h actual %h",
                     $time, want.payload_out, got.payload_out);
            fail_count++;
        end
    endtask

    // watch the channels and the register port
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor = SEQ_MINUS_ONE;
            next_seq = '0;
            gate_cache = SEQ_MINUS_ONE;
            for (int i = 0; i < MAX_READERS; i++)
                reader_pos[i] = SEQ_MINUS_ONE;
            active_cnt = ACTIVE_RESET;
            rsp_due.delete();
            fail_count = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
                compare_rsp(rsp);
            if (cfg_we)
                active_cnt = cfg_wdata;
            if (req_valid && !req_stall)
                rsp_due.push_back(predict_rsp(req));
        end
        pending = rsp_due.size();
    end

endmodule

FILE: tb/gated_broadcast_ring_buffer_test.sv
// Testbench top for the gated broadcast ring buffer: stimulus, idling and verdict
module gated_broadcast_ring_buffer_test import gbrb_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    logic                    clk;
    logic                    rst_n;
    logic                    req_valid;
    logic                    req_stall;
    req_t                    req;
    logic                    rsp_valid;
    logic                    rsp_stall;
    rsp_t                    rsp;
    logic                    cfg_we;
    logic [ACT_W-1:0]        cfg_wdata;
    int                      fail_count;
    int                      pending;
    logic signed [SEQ_W-1:0] cursor_seen;

    // idling knobs and the receiver hold-off counter
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;
    int readers_on    = ACTIVE_RESET;

    // per phase: active readers, publish share, sender idle, receiver stall
    int phase_cfg   [5] = '{0, 1, 8, 15, 4};
    int phase_pub   [5] = '{90, 75, 55, 55, 55};
    int phase_send  [5] = '{0, 50, 0, 16, 0};
    int phase_stall [5] = '{0, 0, 50, 16, 0};

    gated_broadcast_ring_buffer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    gated_broadcast_ring_buffer_check checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .fail_count  (fail_count),
        .pending     (pending),
        .cursor_seen (cursor_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("gated_broadcast_ring_buffer_test failed");
        $finish;
    end

    // receiver: long hold-off when asked, else random stalls
    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                rsp_stall <= 1'b1;
                hold_left--;
            end
            else
                rsp_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // offer one request after random idle cycles, return once it transfers
    task automatic drive_item(input req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    task automatic send_fixed(input op_t op, input int rd,
                              input logic signed [SEQ_W-1:0] sq,
                              input logic [DATA_W-1:0] pl);
        req_t r;
        @(negedge clk);
        r.op = op;
        r.reader = READER_W'(rd);
        r.seq_in = sq;
        r.payload_in = pl;
        drive_item(r);
    endtask

    // write active_readers once every owed response has come back
    task automatic write_active(input int value);
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= ACT_W'(value);
        readers_on = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // random request; reads only touch published slots or land past the cursor
    function automatic req_t random_request(input int pub_pct);
        req_t        r;
        logic [63:0] bits;
        longint      cur;
        longint      s;
        longint      span;
        int          pick;
        int          slot;
        int          lanes;
        bits = {$urandom, $urandom};
        cur = longint'(cursor_seen);
        lanes = (readers_on > MAX_READERS) ? MAX_READERS : readers_on;
        r.payload_in = {$urandom, $urandom};
        r.seq_in = bits[SEQ_W-1:0];
        // favor readers that take part in gating
        if (lanes > 0 && $urandom_range(1) == 1)
            r.reader = READER_W'($urandom_range(lanes - 1));
        else
            r.reader = READER_W'($urandom_range(MAX_READERS - 1));
        pick = $urandom_range(99);
        if (pick < pub_pct)
            r.op = OP_PUBLISH;
        else
        begin
            pick = $urandom_range(19);
            r.op = (pick < 9) ? OP_READ : (pick < 18) ? OP_RELEASE : OP_NOP;
        end
        pick = $urandom_range(99);
        if (r.op == OP_READ)
        begin
            if (cur < 0 || pick < 25)
            begin
                // past the cursor: not yet published
                if (pick % 2 == 1)
                    s = cur + 1 + longint'($urandom_range(3));
                else
                    s = longint'(bits[SEQ_W-2:0]);
                if (s <= cur)
                    s = cur + 1;
                r.seq_in = SEQ_W'(s);
            end
            else if (pick < 70)
            begin
                // recent entries, sometimes more than a lap back
                span = (cur < 1100) ? cur : 1100;
                r.seq_in = SEQ_W'(cur - longint'($urandom_range(int'(span))));
            end
            else if (pick < 85)
                r.seq_in = SEQ_W'(cur);
            else
            begin
                // negative sequence aliasing a slot already written
                slot = $urandom_range((cur < RING_DEPTH) ? int'(cur) : RING_DEPTH - 1);
                r.seq_in = {1'b1, bits[SEQ_W-ADDR_W-2:0], ADDR_W'(slot)};
            end
        end
        else if (r.op == OP_RELEASE)
        begin
            if (pick < 60)
                r.seq_in = SEQ_W'(cur - longint'($urandom_range(RING_DEPTH - 1)));
            else if (pick < 75)
                r.seq_in = SEQ_W'(cur - RING_DEPTH - longint'($urandom_range(400)));
            else if (pick < 85)
                r.seq_in = SEQ_MINUS_ONE;
        end
        return r;
    endfunction

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty ring, field extremes, aliasing and old reads, releases
        send_fixed(OP_READ, 0, '0, '0);
        send_fixed(OP_READ, 0, SEQ_MAX, '0);
        send_fixed(OP_PUBLISH, 0, '0, '0);
        send_fixed(OP_PUBLISH, 7, SEQ_MINUS_ONE, '1);
        send_fixed(OP_PUBLISH, 3, SEQ_MAX, 64'h0123_4567_89ab_cdef);
        send_fixed(OP_READ, 0, SEQ_W'(0), '0);
        send_fixed(OP_READ, 7, SEQ_W'(1), '1);
        send_fixed(OP_READ, 0, SEQ_W'(2), '0);
        send_fixed(OP_READ, 0, SEQ_W'(3), '0);
        send_fixed(OP_READ, 0, SEQ_W'(-1024), '0);
        send_fixed(OP_RELEASE, 0, SEQ_MINUS_ONE, '0);
        send_fixed(OP_RELEASE, 7, SEQ_MAX, '1);
        send_fixed(OP_RELEASE, 3, {1'b1, {(SEQ_W-1){1'b0}}}, '0);
        send_fixed(OP_RELEASE, 1, SEQ_W'(2), '0);
        send_fixed(OP_NOP, 7, SEQ_MINUS_ONE, '1);
        send_fixed(OP_NOP, 0, '0, '0);
        send_fixed(OP_PUBLISH, 5, SEQ_W'(17), 64'hfedc_ba98_7654_3210);
        send_fixed(OP_READ, 7, SEQ_W'(3), '1);

        // random phases across reader counts and idling patterns
        for (int p = 0; p < 5; p++)
        begin
            write_active((p == 4) ? $urandom_range(7, 2) : phase_cfg[p]);
            send_idle_pct = phase_send[p];
            stall_pct = phase_stall[p];
            for (int n = 0; n < 200; n++)
            begin
                @(negedge clk);
                drive_item(random_request(phase_pub[p]));
                // receiver holds off while requests keep coming
                if (p == 4 && n == 100)
                    hold_left = 400;
            end
        end

        @(negedge clk);
        req_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("gated_broadcast_ring_buffer_test passed");
        else
            $display("gated_broadcast_ring_buffer_test failed");
        $finish;
    end

endmodule
